@@ hdl/bus_master_transaction_scheduler_core_assert.svh @@
// ----------------------------------------------------------------------------
// Scheduler assertion macros
// Shared concurrent assertion forms, clocked on clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef BUS_MASTER_TRANSACTION_SCHEDULER_CORE_ASSERT_SVH
`define BUS_MASTER_TRANSACTION_SCHEDULER_CORE_ASSERT_SVH

// same-cycle implication
`define BMTS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BMTS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/bmts_pkg.sv @@
// ----------------------------------------------------------------------------
// bmts_pkg
// Types, codes and constants of the bus master transaction scheduler.
// ----------------------------------------------------------------------------
package bmts_pkg;

  localparam int TIMER_WIDTH_DEF = 16;
  localparam int CFG_AW          = 3;

  localparam logic [15:0] ERROR_TRIGGER = 16'd4444;
  localparam logic [15:0] TIMEOUT_RST   = 16'd100;
  localparam logic [15:0] PERIOD_RST    = 16'd100;

  typedef enum logic {
    REG_TIMEOUT = 1'b0,
    REG_PERIOD  = 1'b1
  } reg_idx_t;

  typedef enum logic [2:0] {
    MODE_ERROR = 3'd0,
    MODE_READY = 3'd1,
    MODE_PTX   = 3'd2,
    MODE_PRX   = 3'd3,
    MODE_STX   = 3'd4,
    MODE_SRX   = 3'd5
  } mode_t;

  typedef enum logic [2:0] {
    KIND_NONE   = 3'd0,
    KIND_PWRITE = 3'd1,
    KIND_PREAD  = 3'd2,
    KIND_SWRITE = 3'd3,
    KIND_SREAD  = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    ACT_TICK   = 3'd0,
    ACT_REPLY  = 3'd1,
    ACT_SWRITE = 3'd2,
    ACT_SREAD  = 3'd3,
    ACT_CLEAR  = 3'd4
  } act_t;

  typedef struct packed {
    logic [15:0] timeout;
    logic [15:0] period;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [15:0] command_word;
    logic [15:0] command_data;
    logic [15:0] service_addr;
    logic [15:0] service_value;
    logic        reply_ok;
    logic [15:0] reply_value;
  } item_t;

  typedef struct packed {
    kind_t       request_kind;
    logic [15:0] request_addr;
    logic [15:0] request_data;
    mode_t       state_code;
    logic        write_confirm_valid;
    logic        write_confirm_ok;
    logic        read_result_valid;
    logic        read_result_ok;
    logic [15:0] read_result_data;
    logic        process_in_valid;
    logic [15:0] process_in_data;
  } result_t;

endpackage

@@ hdl/bmts_cfg.sv @@
// ----------------------------------------------------------------------------
// bmts_cfg
// APB-style register file: protocol timeout and monitor period.
// ----------------------------------------------------------------------------
module bmts_cfg (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [bmts_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output bmts_pkg::cfg_t             cfg
);
  import bmts_pkg::*;

  logic [15:0] timeout_r, timeout_nxt;
  logic [15:0] period_r, period_nxt;
  reg_idx_t    idx;
  logic        wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[2]);
  assign wr_en  = psel && penable && pwrite && pready;

  always_comb begin
    timeout_nxt = timeout_r;
    period_nxt  = period_r;
    prdata      = '0;
    unique case (idx)
      REG_TIMEOUT: begin
        prdata = {16'd0, timeout_r};
        if (wr_en) timeout_nxt = pwdata[15:0];
      end
      REG_PERIOD: begin
        prdata = {16'd0, period_r};
        if (wr_en) period_nxt = pwdata[15:0];
      end
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= TIMEOUT_RST;
      period_r  <= PERIOD_RST;
    end else begin
      timeout_r <= timeout_nxt;
      period_r  <= period_nxt;
    end
  end

  assign cfg.timeout = timeout_r;
  assign cfg.period  = period_r;

endmodule

@@ hdl/bmts_engine.sv @@
// ----------------------------------------------------------------------------
// bmts_engine
// Scheduler state and the single-pass next-state / result logic.
// ----------------------------------------------------------------------------
module bmts_engine #(
  parameter int TIMER_WIDTH = bmts_pkg::TIMER_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  bmts_pkg::cfg_t    cfg,
  input  bmts_pkg::item_t   item,
  output bmts_pkg::result_t res
);
  import bmts_pkg::*;

  localparam int CW = (TIMER_WIDTH > 16) ? TIMER_WIDTH : 16;

  mode_t                  mode_r, mode_nxt;
  logic [TIMER_WIDTH-1:0] ptimer_r, ptimer_nxt;
  logic [TIMER_WIDTH-1:0] mtimer_r, mtimer_nxt;
  logic [15:0]            prev_cmd_r, prev_cmd_nxt;
  logic                   ppend_r, ppend_nxt;
  logic [15:0]            pdata_r, pdata_nxt;
  logic                   swp_r, swp_nxt;
  logic [15:0]            swa_r, swa_nxt;
  logic [15:0]            swd_r, swd_nxt;
  logic                   srp_r, srp_nxt;
  logic [15:0]            sra_r, sra_nxt;

  logic [CW-1:0] tmo_cw, per_cw;
  act_t          act;

  assign tmo_cw = CW'(cfg.timeout);
  assign per_cw = CW'(cfg.period);
  assign act    = act_t'(item.action);

  always_comb begin
    mode_nxt     = mode_r;
    ptimer_nxt   = ptimer_r;
    mtimer_nxt   = mtimer_r;
    prev_cmd_nxt = prev_cmd_r;
    ppend_nxt    = ppend_r;
    pdata_nxt    = pdata_r;
    swp_nxt      = swp_r;
    swa_nxt      = swa_r;
    swd_nxt      = swd_r;
    srp_nxt      = srp_r;
    sra_nxt      = sra_r;
    res          = '0;

    unique case (act)
      ACT_TICK: begin
        if (mode_r != MODE_ERROR) begin
          // protocol timeout
          if (CW'(ptimer_r) >= tmo_cw) begin
            ptimer_nxt = tmo_cw[TIMER_WIDTH-1:0];
            if (mode_r != MODE_READY) begin
              if (mode_r == MODE_STX) begin
                res.write_confirm_valid = 1'b1;
              end else if (mode_r == MODE_SRX) begin
                res.read_result_valid = 1'b1;
              end
              ptimer_nxt = '0;
              mode_nxt   = MODE_READY;
            end
          end else if (ptimer_r != '0) begin
            ptimer_nxt = ptimer_r + 1'b1;
          end

          // held requests, fixed priority
          if (mode_nxt == MODE_READY) begin
            if (ppend_r) begin
              res.request_kind = KIND_PWRITE;
              res.request_data = pdata_r;
              ptimer_nxt       = TIMER_WIDTH'(1);
              mode_nxt         = MODE_PTX;
              ppend_nxt        = 1'b0;
            end else if (swp_r) begin
              res.request_kind = KIND_SWRITE;
              res.request_addr = swa_r;
              res.request_data = swd_r;
              ptimer_nxt       = TIMER_WIDTH'(1);
              mode_nxt         = MODE_STX;
              swp_nxt          = 1'b0;
            end else if (srp_r) begin
              res.request_kind = KIND_SREAD;
              res.request_addr = sra_r;
              ptimer_nxt       = TIMER_WIDTH'(1);
              mode_nxt         = MODE_SRX;
              srp_nxt          = 1'b0;
            end
          end

          // command word rising from zero
          if (item.command_word != '0 && prev_cmd_r == '0) begin
            if (item.command_word == ERROR_TRIGGER) begin
              mode_nxt = MODE_ERROR;
            end else if (mode_nxt == MODE_READY) begin
              res.request_kind = KIND_PWRITE;
              res.request_addr = '0;
              res.request_data = item.command_data;
              ptimer_nxt       = TIMER_WIDTH'(1);
              mode_nxt         = MODE_PTX;
            end else begin
              pdata_nxt = item.command_data;
              ppend_nxt = 1'b1;
            end
          end

          // monitor period
          if (CW'(mtimer_r) >= per_cw) begin
            mtimer_nxt = per_cw[TIMER_WIDTH-1:0];
          end else begin
            mtimer_nxt = mtimer_r + 1'b1;
          end
          if (CW'(mtimer_nxt) == per_cw && mode_nxt == MODE_READY) begin
            res.request_kind = KIND_PREAD;
            res.request_addr = '0;
            res.request_data = '0;
            ptimer_nxt       = TIMER_WIDTH'(1);
            mode_nxt         = MODE_PRX;
            mtimer_nxt       = '0;
          end
        end
        prev_cmd_nxt = item.command_word;
      end

      ACT_REPLY: begin
        if (mode_r == MODE_PRX) begin
          if (item.reply_ok) begin
            res.process_in_valid = 1'b1;
            res.process_in_data  = item.reply_value;
          end
        end else if (mode_r == MODE_STX) begin
          res.write_confirm_valid = 1'b1;
          res.write_confirm_ok    = item.reply_ok;
        end else if (mode_r == MODE_SRX) begin
          res.read_result_valid = 1'b1;
          res.read_result_ok    = item.reply_ok;
          res.read_result_data  = item.reply_ok ? item.reply_value : 16'd0;
        end
        ptimer_nxt = '0;
        mode_nxt   = MODE_READY;
      end

      ACT_SWRITE: begin
        if (mode_r == MODE_READY) begin
          res.request_kind = KIND_SWRITE;
          res.request_addr = item.service_addr;
          res.request_data = item.service_value;
          ptimer_nxt       = TIMER_WIDTH'(1);
          mode_nxt         = MODE_STX;
        end else if (mode_r != MODE_ERROR) begin
          swa_nxt = item.service_addr;
          swd_nxt = item.service_value;
          swp_nxt = 1'b1;
        end
      end

      ACT_SREAD: begin
        if (mode_r == MODE_READY) begin
          res.request_kind = KIND_SREAD;
          res.request_addr = item.service_addr;
          ptimer_nxt       = TIMER_WIDTH'(1);
          mode_nxt         = MODE_SRX;
        end else if (mode_r != MODE_ERROR) begin
          sra_nxt = item.service_addr;
          srp_nxt = 1'b1;
        end
      end

      ACT_CLEAR: begin
        if (mode_r == MODE_ERROR) begin
          ppend_nxt    = 1'b0;
          swp_nxt      = 1'b0;
          srp_nxt      = 1'b0;
          ptimer_nxt   = '0;
          mtimer_nxt   = '0;
          prev_cmd_nxt = item.command_word;
          mode_nxt     = MODE_READY;
        end
      end

      default: ;
    endcase

    res.state_code = mode_nxt;
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= MODE_READY;
      ptimer_r   <= '0;
      mtimer_r   <= '0;
      prev_cmd_r <= '0;
      ppend_r    <= 1'b0;
      swp_r      <= 1'b0;
      srp_r      <= 1'b0;
    end else if (en) begin
      mode_r     <= mode_nxt;
      ptimer_r   <= ptimer_nxt;
      mtimer_r   <= mtimer_nxt;
      prev_cmd_r <= prev_cmd_nxt;
      ppend_r    <= ppend_nxt;
      swp_r      <= swp_nxt;
      srp_r      <= srp_nxt;
    end
  end

  // held request payloads, only read behind their flags
  always_ff @(posedge clk) begin
    if (en) begin
      pdata_r <= pdata_nxt;
      swa_r   <= swa_nxt;
      swd_r   <= swd_nxt;
      sra_r   <= sra_nxt;
    end
  end

endmodule

@@ hdl/bus_master_transaction_scheduler_core.sv @@
// ----------------------------------------------------------------------------
// bus_master_transaction_scheduler_core
// Field-bus master transaction scheduler: input register, single-pass
// scheduling logic, result register, APB-style configuration.
// ----------------------------------------------------------------------------
// Flow: an accepted request is held in the input register; the scheduling
//   logic computes its result, which the result register holds for out_valid.
// Throughput: one request per cycle; the scheduling logic between the two
//   registers is single-pass. A stalled result holds the result register,
//   and with the input register full in_stall follows.
// Reset: rst_n synchronous, active low; mode ready, timers and pending
//   flags cleared, timeout and period registers back to 100.
// ----------------------------------------------------------------------------
module bus_master_transaction_scheduler_core #(
  parameter int TIMER_WIDTH = bmts_pkg::TIMER_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // request channel
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [2:0]                  in_action,
  input  logic [15:0]                 in_command_word,
  input  logic [15:0]                 in_command_data,
  input  logic [15:0]                 in_service_addr,
  input  logic [15:0]                 in_service_value,
  input  logic                        in_reply_ok,
  input  logic [15:0]                 in_reply_value,
  // result channel
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [2:0]                  out_request_kind,
  output logic [15:0]                 out_request_addr,
  output logic [15:0]                 out_request_data,
  output logic [2:0]                  out_state_code,
  output logic                        out_write_confirm_valid,
  output logic                        out_write_confirm_ok,
  output logic                        out_read_result_valid,
  output logic                        out_read_result_ok,
  output logic [15:0]                 out_read_result_data,
  output logic                        out_process_in_valid,
  output logic [15:0]                 out_process_in_data,
  // configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bmts_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import bmts_pkg::*;

  cfg_t    cfg;
  item_t   item_r, item_nxt;
  logic    in_vld_r, in_vld_nxt;
  result_t res;
  result_t out_res_r;
  logic    out_vld_r, out_vld_nxt;
  logic    in_acc;
  logic    advance;

  // Input register advances when the result register is empty or being
  // drained this cycle, so a result leaving now frees room for the next
  // request in the same cycle.
  assign advance  = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = in_vld_r && !advance;
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    item_nxt.action        = in_action;
    item_nxt.command_word  = in_command_word;
    item_nxt.command_data  = in_command_data;
    item_nxt.service_addr  = in_service_addr;
    item_nxt.service_value = in_service_value;
    item_nxt.reply_ok      = in_reply_ok;
    item_nxt.reply_value   = in_reply_value;
  end

  always_comb begin
    if (in_acc) begin
      in_vld_nxt = 1'b1;
    end else if (advance) begin
      in_vld_nxt = 1'b0;
    end else begin
      in_vld_nxt = in_vld_r;
    end
    out_vld_nxt = advance || (out_vld_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) item_r <= item_nxt;
    if (advance) out_res_r <= res;
  end

  bmts_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  bmts_engine #(
    .TIMER_WIDTH (TIMER_WIDTH)
  ) u_engine (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (advance),
    .cfg   (cfg),
    .item  (item_r),
    .res   (res)
  );

  assign out_valid               = out_vld_r;
  assign out_request_kind        = out_res_r.request_kind;
  assign out_request_addr        = out_res_r.request_addr;
  assign out_request_data        = out_res_r.request_data;
  assign out_state_code          = out_res_r.state_code;
  assign out_write_confirm_valid = out_res_r.write_confirm_valid;
  assign out_write_confirm_ok    = out_res_r.write_confirm_ok;
  assign out_read_result_valid   = out_res_r.read_result_valid;
  assign out_read_result_ok      = out_res_r.read_result_ok;
  assign out_read_result_data    = out_res_r.read_result_data;
  assign out_process_in_valid    = out_res_r.process_in_valid;
  assign out_process_in_data     = out_res_r.process_in_data;

endmodule

@@ hdl/bmts_checker.sv @@
// ----------------------------------------------------------------------------
// bmts_checker
// Port-level assertions on the scheduler result channel, bound to the core.
// ----------------------------------------------------------------------------
`include "bus_master_transaction_scheduler_core_assert.svh"

module bmts_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  out_request_kind,
  input logic [2:0]  out_state_code,
  input logic        out_write_confirm_valid,
  input logic        out_write_confirm_ok,
  input logic        out_read_result_ok,
  input logic [15:0] out_read_result_data,
  input logic        out_process_in_valid
);
  import bmts_pkg::*;

  // stalled result holds
  `BMTS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_request_kind), "result changed while stalled")

  // an issued request always leaves the block busy or in error
  `BMTS_ASSERT_IMPL(a_req_busy, out_valid && out_request_kind != KIND_NONE, out_state_code != MODE_READY, "request issued but mode is ready")

  // read data only carries a successful read
  `BMTS_ASSERT_IMPL(a_rd_data, out_valid && !out_read_result_ok, out_read_result_data == 16'd0, "read data without successful read")

  // confirm ok only with a confirm
  `BMTS_ASSERT_IMPL(a_wc_ok, out_valid && out_write_confirm_ok, out_write_confirm_valid, "confirm ok without confirm valid")

  // monitor data comes from a reply: no request, back to ready
  `BMTS_ASSERT_IMPL(a_pin_reply, out_valid && out_process_in_valid, out_request_kind == KIND_NONE && out_state_code == MODE_READY, "process input outside a reply")

endmodule

bind bus_master_transaction_scheduler_core bmts_checker u_bmts_checker (.*);

@@ test/testbench.sv @@
// ----------------------------------------------------------------------------
// Transaction scheduler testbench
// Drives requests and register writes into the scheduler core and checks
// every result against a cycle-free model of the scheduling rules, kept in a
// small checker object. Random gaps and stalls run on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
  import bmts_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int TW          = TIMER_WIDTH_DEF;
  localparam int NPHASE      = 9;

  // --------------------------------------------------------------------------
  // Expected-behavior tracker: mirrors mode, timers and held requests, and
  // queues the result each accepted request should produce.
  // --------------------------------------------------------------------------
  class schedule_checker;
    logic [15:0]   timeout;
    logic [15:0]   period;
    mode_t         mode;
    logic [TW-1:0] proto_timer;
    logic [TW-1:0] mon_timer;
    logic [15:0]   last_cmd;
    bit            pw_held;
    logic [15:0]   pw_data;
    bit            sw_held;
    logic [15:0]   sw_addr;
    logic [15:0]   sw_data;
    bit            sr_held;
    logic [15:0]   sr_addr;
    result_t       due_results[$];
    int            errors;

    function new();
      timeout     = TIMEOUT_RST;
      period      = PERIOD_RST;
      mode        = MODE_READY;
      proto_timer = '0;
      mon_timer   = '0;
      last_cmd    = '0;
      pw_held     = 0;
      sw_held     = 0;
      sr_held     = 0;
      pw_data     = '0;
      sw_addr     = '0;
      sw_data     = '0;
      sr_addr     = '0;
      errors      = 0;
    endfunction

    function void set_timing(reg_idx_t idx, logic [15:0] val);
      if (idx == REG_TIMEOUT) timeout = val;
      else period = val;
    endfunction

    function int pending();
      return due_results.size();
    endfunction

    // start a transaction: drive the request and arm the protocol timer
    function void launch(inout result_t r, input kind_t k, input logic [15:0] a,
                         input logic [15:0] d, input mode_t nxt);
      r.request_kind = k;
      r.request_addr = a;
      r.request_data = d;
      proto_timer    = 1;
      mode           = nxt;
    endfunction

    function void on_tick(item_t it, inout result_t r);
      if (mode != MODE_ERROR) begin
        // protocol timeout first
        if (proto_timer >= timeout) begin
          proto_timer = TW'(timeout);
          if (mode != MODE_READY) begin
            if (mode == MODE_STX) begin
              r.write_confirm_valid = 1'b1;
            end else if (mode == MODE_SRX) begin
              r.read_result_valid = 1'b1;
            end
            proto_timer = '0;
            mode        = MODE_READY;
          end
        end else if (proto_timer != 0) begin
          proto_timer = proto_timer + 1'b1;
        end
        // held requests, fixed priority
        if (mode == MODE_READY) begin
          if (pw_held) begin
            launch(r, KIND_PWRITE, 16'h0, pw_data, MODE_PTX);
            pw_held = 0;
          end else if (sw_held) begin
            launch(r, KIND_SWRITE, sw_addr, sw_data, MODE_STX);
            sw_held = 0;
          end else if (sr_held) begin
            launch(r, KIND_SREAD, sr_addr, 16'h0, MODE_SRX);
            sr_held = 0;
          end
        end
        // command word rising from zero
        if (it.command_word != 0 && last_cmd == 0) begin
          if (it.command_word == ERROR_TRIGGER) begin
            mode = MODE_ERROR;
          end else if (mode == MODE_READY) begin
            launch(r, KIND_PWRITE, 16'h0, it.command_data, MODE_PTX);
          end else begin
            pw_data = it.command_data;
            pw_held = 1;
          end
        end
        // periodic monitor read
        if (mon_timer >= period) mon_timer = TW'(period);
        else mon_timer = mon_timer + 1'b1;
        if (mon_timer == period && mode == MODE_READY) begin
          launch(r, KIND_PREAD, 16'h0, 16'h0, MODE_PRX);
          mon_timer = '0;
        end
      end
      last_cmd = it.command_word;
    endfunction

    function void on_reply(item_t it, inout result_t r);
      if (mode == MODE_PRX) begin
        if (it.reply_ok) begin
          r.process_in_valid = 1'b1;
          r.process_in_data  = it.reply_value;
        end
      end else if (mode == MODE_STX) begin
        r.write_confirm_valid = 1'b1;
        r.write_confirm_ok    = it.reply_ok;
      end else if (mode == MODE_SRX) begin
        r.read_result_valid = 1'b1;
        r.read_result_ok    = it.reply_ok;
        r.read_result_data  = it.reply_ok ? it.reply_value : 16'h0;
      end
      proto_timer = '0;
      mode        = MODE_READY;
    endfunction

    function result_t next_result(item_t it);
      result_t r;
      r = '0;
      case (it.action)
        ACT_TICK:  on_tick(it, r);
        ACT_REPLY: on_reply(it, r);
        ACT_SWRITE: begin
          if (mode == MODE_READY) begin
            launch(r, KIND_SWRITE, it.service_addr, it.service_value, MODE_STX);
          end else if (mode != MODE_ERROR) begin
            sw_addr = it.service_addr;
            sw_data = it.service_value;
            sw_held = 1;
          end
        end
        ACT_SREAD: begin
          if (mode == MODE_READY) begin
            launch(r, KIND_SREAD, it.service_addr, 16'h0, MODE_SRX);
          end else if (mode != MODE_ERROR) begin
            sr_addr = it.service_addr;
            sr_held = 1;
          end
        end
        ACT_CLEAR: begin
          if (mode == MODE_ERROR) begin
            pw_held     = 0;
            sw_held     = 0;
            sr_held     = 0;
            proto_timer = '0;
            mon_timer   = '0;
            last_cmd    = it.command_word;
            mode        = MODE_READY;
          end
        end
        default: ;
      endcase
      r.state_code = mode;
      return r;
    endfunction

    function void note_request(item_t it);
      due_results.push_back(next_result(it));
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
        errors++;
        if (errors <= 10)
          $display("mismatch on %s: expected %h, actual %h", name, want, got);
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (due_results.size() == 0) begin
        errors++;
        if (errors <= 10) $display("result with no request outstanding: %h", got);
        return;
      end
      want = due_results.pop_front();
      compare_field("request_kind", want.request_kind, got.request_kind);
      compare_field("request_addr", want.request_addr, got.request_addr);
      compare_field("request_data", want.request_data, got.request_data);
      compare_field("state_code", want.state_code, got.state_code);
      compare_field("write_confirm_valid", want.write_confirm_valid,
                    got.write_confirm_valid);
      compare_field("write_confirm_ok", want.write_confirm_ok, got.write_confirm_ok);
      compare_field("read_result_valid", want.read_result_valid, got.read_result_valid);
      compare_field("read_result_ok", want.read_result_ok, got.read_result_ok);
      compare_field("read_result_data", want.read_result_data, got.read_result_data);
      compare_field("process_in_valid", want.process_in_valid, got.process_in_valid);
      compare_field("process_in_data", want.process_in_data, got.process_in_data);
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // DUT signals
  // --------------------------------------------------------------------------
  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic [2:0]        in_action;
  logic [15:0]       in_command_word;
  logic [15:0]       in_command_data;
  logic [15:0]       in_service_addr;
  logic [15:0]       in_service_value;
  logic              in_reply_ok;
  logic [15:0]       in_reply_value;
  logic              out_valid;
  logic              out_stall;
  logic [2:0]        out_request_kind;
  logic [15:0]       out_request_addr;
  logic [15:0]       out_request_data;
  logic [2:0]        out_state_code;
  logic              out_write_confirm_valid;
  logic              out_write_confirm_ok;
  logic              out_read_result_valid;
  logic              out_read_result_ok;
  logic [15:0]       out_read_result_data;
  logic              out_process_in_valid;
  logic [15:0]       out_process_in_data;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  schedule_checker sb;
  int unsigned     cycles;
  logic [15:0]     host_cmd;      // command word as the host buffer holds it
  logic [15:0]     ph_timeout[NPHASE];
  logic [15:0]     ph_period[NPHASE];
  int              ph_items[NPHASE];

  bus_master_transaction_scheduler_core u_top (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .in_valid                (in_valid),
    .in_stall                (in_stall),
    .in_action               (in_action),
    .in_command_word         (in_command_word),
    .in_command_data         (in_command_data),
    .in_service_addr         (in_service_addr),
    .in_service_value        (in_service_value),
    .in_reply_ok             (in_reply_ok),
    .in_reply_value          (in_reply_value),
    .out_valid               (out_valid),
    .out_stall               (out_stall),
    .out_request_kind        (out_request_kind),
    .out_request_addr        (out_request_addr),
    .out_request_data        (out_request_data),
    .out_state_code          (out_state_code),
    .out_write_confirm_valid (out_write_confirm_valid),
    .out_write_confirm_ok    (out_write_confirm_ok),
    .out_read_result_valid   (out_read_result_valid),
    .out_read_result_ok      (out_read_result_ok),
    .out_read_result_data    (out_read_result_data),
    .out_process_in_valid    (out_process_in_valid),
    .out_process_in_data     (out_process_in_data),
    .psel                    (psel),
    .penable                 (penable),
    .pwrite                  (pwrite),
    .paddr                   (paddr),
    .pwdata                  (pwdata),
    .prdata                  (prdata),
    .pready                  (pready)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic item_t mk(logic [2:0] act, logic [15:0] cmd, logic [15:0] data,
                               logic [15:0] addr, logic [15:0] val, logic ok,
                               logic [15:0] rval);
    item_t it;
    it.action        = act;
    it.command_word  = cmd;
    it.command_data  = data;
    it.service_addr  = addr;
    it.service_value = val;
    it.reply_ok      = ok;
    it.reply_value   = rval;
    return it;
  endfunction

  // Random request. The command word follows a host-like pattern: held for
  // a while, dropped to zero, then raised again, so rising edges are common.
  function automatic item_t random_item();
    item_t it;
    int    sel;
    int    cw;
    cw = $urandom_range(0, 99);
    if (cw < 85) begin
      // keep
    end else if (cw < 93) begin
      host_cmd = 16'h0;
    end else if (cw < 99) begin
      host_cmd = 16'($urandom_range(1, 65535));
    end else begin
      host_cmd = ERROR_TRIGGER;
    end
    sel = $urandom_range(0, 99);
    it  = mk(ACT_TICK, host_cmd, 16'($urandom), 16'($urandom), 16'($urandom),
             ($urandom_range(0, 99) < 80), 16'($urandom));
    if (sel < 50) it.action = ACT_TICK;
    else if (sel < 68) it.action = ACT_REPLY;
    else if (sel < 79) it.action = ACT_SWRITE;
    else if (sel < 90) it.action = ACT_SREAD;
    else if (sel < 97) it.action = ACT_CLEAR;
    else it.action = 3'(ACT_CLEAR) + 3'($urandom_range(1, 3));  // unused codes
    return it;
  endfunction

  // Present one request after an optional gap, hold until accepted.
  task automatic drive_request(item_t it, int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_action        <= it.action;
    in_command_word  <= it.command_word;
    in_command_data  <= it.command_data;
    in_service_addr  <= it.service_addr;
    in_service_value <= it.service_value;
    in_reply_ok      <= it.reply_ok;
    in_reply_value   <= it.reply_value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(it);
  endtask

  // APB write: setup then access, done when pready is seen in access
  task automatic cfg_write(reg_idx_t idx, logic [15:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_AW'({idx, 2'b00});
    pwdata  <= {16'h0, val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_timing(idx, val);
  endtask

  // drop valid, let every outstanding result drain, then cover pipe latency
  task automatic drain(int slack);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (slack) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Result side: random stall with free-running stretches, and the checker
  // --------------------------------------------------------------------------
  initial begin
    int n;
    out_stall <= 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      n = pick_gap();
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      if ($urandom_range(0, 19) == 0) repeat ($urandom_range(40, 150)) @(posedge clk);
      else repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    result_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.request_kind        = kind_t'(out_request_kind);
      got.request_addr        = out_request_addr;
      got.request_data        = out_request_data;
      got.state_code          = mode_t'(out_state_code);
      got.write_confirm_valid = out_write_confirm_valid;
      got.write_confirm_ok    = out_write_confirm_ok;
      got.read_result_valid   = out_read_result_valid;
      got.read_result_ok      = out_read_result_ok;
      got.read_result_data    = out_read_result_data;
      got.process_in_valid    = out_process_in_valid;
      got.process_in_data     = out_process_in_data;
      sb.check_result(got);
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int gap;
    int quiet;
    sb       = new();
    host_cmd = 16'h0;
    quiet    = 0;
    rst_n            <= 1'b0;
    in_valid         <= 1'b0;
    in_action        <= ACT_TICK;
    in_command_word  <= 16'h0;
    in_command_data  <= 16'h0;
    in_service_addr  <= 16'h0;
    in_service_value <= 16'h0;
    in_reply_ok      <= 1'b0;
    in_reply_value   <= 16'h0;
    psel             <= 1'b0;
    penable          <= 1'b0;
    pwrite           <= 1'b0;
    paddr            <= '0;
    pwdata           <= 32'h0;

    // timing phases: defaults, extremes (incl. zero), a few small mixes
    ph_timeout = '{16'd100, 16'd1, 16'd0, 16'd3, 16'd65535, 16'd65535, 16'd1,
                   16'd6, 16'd0};
    ph_period  = '{16'd100, 16'd1, 16'd0, 16'd5, 16'd65535, 16'd1, 16'd65535,
                   16'd12, 16'd0};
    ph_items   = '{150, 200, 150, 250, 80, 100, 100, 200, 220};
    ph_timeout[NPHASE-1] = 16'($urandom_range(1, 40));
    ph_period[NPHASE-1]  = 16'($urandom_range(1, 40));

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part: short timeout and period so every path shows up quickly
    cfg_write(REG_TIMEOUT, 16'd2);
    cfg_write(REG_PERIOD, 16'd3);
    drive_request(mk(ACT_REPLY, 16'h0, 16'h0, 16'h0, 16'h0, 1'b1, 16'hffff), 0); // idle
    drive_request(mk(ACT_CLEAR, 16'h0, 16'h0, 16'h0, 16'h0, 1'b0, 16'h0), 0);    // no error
    drive_request(mk(3'(ACT_CLEAR) + 3'd1, 16'hffff, 16'hffff, 16'hffff, 16'hffff,
                     1'b1, 16'hffff), 0);
    drive_request(mk(3'(ACT_CLEAR) + 3'd2, 16'h0, 16'h0, 16'h0, 16'h0, 1'b0, 16'h0), 0);
    drive_request(mk(3'(ACT_CLEAR) + 3'd3, 16'h0, 16'h0, 16'h0, 16'h0, 1'b0, 16'h0), 0);
    drive_request(mk(ACT_SWRITE, 16'h0, 16'h0, 16'hffff, 16'hffff, 1'b0, 16'h0), 0);
    // held while busy, second read replaces first
    drive_request(mk(ACT_SREAD, 16'h0, 16'h0, 16'h0000, 16'h0, 1'b0, 16'h0), 0);
    drive_request(mk(ACT_SREAD, 16'h0, 16'h0, 16'h1234, 16'h0, 1'b0, 16'h0), 0);
    drive_request(mk(ACT_SWRITE, 16'h0, 16'h0, 16'h00ff, 16'hff00, 1'b0, 16'h0), 0);
    drive_request(mk(ACT_TICK, 16'h0001, 16'hffff, 16'h0, 16'h0, 1'b0, 16'h0), 0);
    drive_request(mk(ACT_REPLY, 16'h0001, 16'h0, 16'h0, 16'h0, 1'b1, 16'h0), 0);
    drive_request(mk(ACT_TICK, 16'h0001, 16'h0, 16'h0, 16'h0, 1'b0, 16'h0), 0);
    drive_request(mk(ACT_REPLY, 16'h0001, 16'h0, 16'h0, 16'h0, 1'b0, 16'h0), 0);
    // let timeouts expire on the held service transactions
    repeat (5) drive_request(mk(ACT_TICK, 16'h0, 16'h0, 16'h0, 16'h0, 1'b0, 16'h0), 0);
    drive_request(mk(ACT_REPLY, 16'h0, 16'h0, 16'h0, 16'h0, 1'b1, 16'hffff), 0);
    // error trigger, ignored requests, clear
    drive_request(mk(ACT_TICK, ERROR_TRIGGER, 16'h0, 16'h0, 16'h0, 1'b0, 16'h0), 0);
    drive_request(mk(ACT_SWRITE, 16'h0, 16'h0, 16'h5555, 16'haaaa, 1'b0, 16'h0), 0);
    drive_request(mk(ACT_TICK, 16'h0, 16'h0, 16'h0, 16'h0, 1'b0, 16'h0), 0);
    drive_request(mk(ACT_CLEAR, 16'hffff, 16'h0, 16'h0, 16'h0, 1'b0, 16'h0), 0);
    drive_request(mk(ACT_SREAD, 16'h0, 16'h0, 16'hffff, 16'h0, 1'b0, 16'h0), 0);
    drive_request(mk(ACT_REPLY, 16'h0, 16'h0, 16'h0, 16'h0, 1'b1, 16'hffff), 0);
    drive_request(mk(ACT_TICK, 16'h0, 16'h0, 16'h0, 16'h0, 1'b0, 16'h0), 0);
    drive_request(mk(ACT_TICK, 16'hffff, 16'h0000, 16'h0, 16'h0, 1'b0, 16'h0), 0);

    // random phases, timing registers changed only when drained
    for (int p = 0; p < NPHASE; p++) begin
      drain(4);
      cfg_write(REG_TIMEOUT, ph_timeout[p]);
      cfg_write(REG_PERIOD, ph_period[p]);
      for (int i = 0; i < ph_items[p]; i++) begin
        if (quiet > 0) begin
          quiet--;
          gap = 0;
        end else begin
          gap = pick_gap();
          if ($urandom_range(0, 99) == 0) quiet = $urandom_range(30, 80);
        end
        drive_request(random_item(), gap);
      end
    end

    drain(10);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
